### rtl/iwrf_pkg.sv
// Package for the interval window range finder.
// Shared constants, action codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package iwrf_pkg;

    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int DEF_TICK_BITS   = 32;
    localparam int IN_TICK_BITS    = 32;   // width of tick fields on the ports
    localparam int RANGE_BITS      = 13;   // width of range fields on the ports

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_in;    // capture input beat
        logic do_append;  // store interval or flag full table
        logic q_init;     // set up first search
        logic s1_step;    // one step of the prefix-max end search
        logic s2_step;    // one step of the start search
        logic out_load;   // move result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic count_zero; // table empty
        logic step_more;  // current search keeps going
        logic s2_more;    // start search has a non-empty span
    } t_stat;

endpackage

`default_nettype wire

### rtl/iwrf_datapath.sv
// Datapath of the interval window range finder: interval table memory,
// binary search bounds, result and output registers.
// Depends on iwrf_pkg.
`default_nettype none

module iwrf_datapath
    import iwrf_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int TICK_BITS   = DEF_TICK_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_stat                        o_stat,
    input  wire logic                    i_new_set,
    input  wire logic [IN_TICK_BITS-1:0] i_start_tick,
    input  wire logic [IN_TICK_BITS-1:0] i_end_tick,
    input  wire logic [IN_TICK_BITS-1:0] i_window_low,
    input  wire logic [IN_TICK_BITS-1:0] i_window_high,
    output logic      [RANGE_BITS-1:0]   o_range_low,
    output logic      [RANGE_BITS-1:0]   o_range_high,
    output logic                         o_append_rejected
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int TB = TICK_BITS;

    // table: start tick in the upper half, prefix-max end in the lower half
    logic [2*TB-1:0] r_mem [MAX_ENTRIES];
    logic [2*TB-1:0] r_rd_data;

    logic          r_new_set;
    logic [TB-1:0] r_start, r_end, r_wlow, r_whigh;
    logic [CW-1:0] r_count, n_count;
    logic [TB-1:0] r_run_max, n_run_max;
    logic [CW-1:0] r_left, r_right, r_mid, r_lo;
    logic [CW-1:0] r_res_low, r_res_high;
    logic          r_res_rej;

    logic [TB+IN_TICK_BITS-1:0] ext_start, ext_end, ext_wlow, ext_whigh;
    logic [CW-1:0] eff_count;
    logic [TB-1:0] eff_max, new_max, rd_start, rd_end;
    logic          full, mem_we, go_right, rd_en;
    logic [CW-1:0] nl, nr, mid_a, mid_b, mid_next;
    logic [CW:0]   mid_sum;
    logic [RANGE_BITS+CW-1:0] ext_low, ext_high;

    assign ext_start = {{TB{1'b0}}, i_start_tick};
    assign ext_end   = {{TB{1'b0}}, i_end_tick};
    assign ext_wlow  = {{TB{1'b0}}, i_window_low};
    assign ext_whigh = {{TB{1'b0}}, i_window_high};

    // append
    assign eff_count = r_new_set ? '0 : r_count;
    assign eff_max   = r_new_set ? '0 : r_run_max;
    assign full      = (eff_count == CW'(MAX_ENTRIES));
    assign new_max   = (r_end > eff_max) ? r_end : eff_max;
    assign mem_we    = i_cmd.do_append && !full;

    // search step
    assign rd_start = r_rd_data[2*TB-1:TB];
    assign rd_end   = r_rd_data[TB-1:0];
    assign go_right = i_cmd.s2_step ? (rd_start <= r_whigh) : (rd_end < r_wlow);
    assign nl       = go_right ? (r_mid + CW'(1)) : r_left;
    assign nr       = go_right ? r_right : r_mid;

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.step_more  = (nl < nr);
    assign o_stat.s2_more    = (nl < r_count);

    // bounds of the next span; the start search begins at the first search's answer
    always_comb begin
        mid_a = nl;
        mid_b = nr;
        if (i_cmd.q_init) begin
            mid_a = '0;
            mid_b = r_count;
        end else if (i_cmd.s1_step && !o_stat.step_more) begin
            mid_b = r_count;
        end
    end

    assign mid_sum  = {1'b0, mid_a} + {1'b0, mid_b};
    assign mid_next = mid_sum[CW:1];
    assign rd_en    = (i_cmd.q_init && !o_stat.count_zero)
                   || (i_cmd.s1_step && (o_stat.step_more || o_stat.s2_more))
                   || (i_cmd.s2_step && o_stat.step_more);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[eff_count[AW-1:0]] <= {r_start, new_max};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[mid_next[AW-1:0]];
        end
    end

    always_comb begin
        n_count   = r_count;
        n_run_max = r_run_max;
        if (mem_we) begin
            n_count   = eff_count + CW'(1);
            n_run_max = new_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_run_max <= '0;
        end else begin
            r_count   <= n_count;
            r_run_max <= n_run_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_new_set <= i_new_set;
            r_start   <= ext_start[TB-1:0];
            r_end     <= ext_end[TB-1:0];
            r_wlow    <= ext_wlow[TB-1:0];
            r_whigh   <= ext_whigh[TB-1:0];
        end
        if (rd_en) begin
            r_left  <= mid_a;
            r_right <= mid_b;
            r_mid   <= mid_next;
        end
        if (i_cmd.do_append) begin
            r_res_low  <= '0;
            r_res_high <= '0;
            r_res_rej  <= full;
        end
        if (i_cmd.q_init) begin
            r_res_low  <= '0;
            r_res_high <= '0;
            r_res_rej  <= 1'b0;
        end
        if (i_cmd.s1_step && !o_stat.step_more) begin
            r_lo <= nl;
            if (!o_stat.s2_more) begin
                r_res_low  <= nl;
                r_res_high <= nl;
            end
        end
        if (i_cmd.s2_step && !o_stat.step_more) begin
            r_res_low  <= r_lo;
            r_res_high <= nl;
        end
    end

    assign ext_low  = {{RANGE_BITS{1'b0}}, r_res_low};
    assign ext_high = {{RANGE_BITS{1'b0}}, r_res_high};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_range_low       <= ext_low[RANGE_BITS-1:0];
            o_range_high      <= ext_high[RANGE_BITS-1:0];
            o_append_rejected <= r_res_rej;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_probe_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.s1_step || i_cmd.s2_step) |-> (r_mid < r_count && r_left < r_right))
        else $error("search probe outside live table");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_count == $past(eff_count) + CW'(1))
        else $error("append did not advance entry count");

endmodule

`default_nettype wire

### rtl/iwrf_ctrl.sv
// Controller of the interval window range finder: sequences append,
// the two binary searches and the output handoff. Depends on iwrf_pkg.
`default_nettype none

module iwrf_ctrl
    import iwrf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire logic  i_action,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_APPEND = 3'd1;
    localparam logic [2:0] ST_QINIT  = 3'd2;
    localparam logic [2:0] ST_SRCH1  = 3'd3;
    localparam logic [2:0] ST_SRCH2  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_action == ACT_QUERY) ? ST_QINIT : ST_APPEND;
                end
            end
            ST_APPEND: begin
                o_cmd.do_append = 1'b1;
                n_state = ST_DONE;
            end
            ST_QINIT: begin
                o_cmd.q_init = 1'b1;
                n_state = i_stat.count_zero ? ST_DONE : ST_SRCH1;
            end
            ST_SRCH1: begin
                o_cmd.s1_step = 1'b1;
                if (!i_stat.step_more) begin
                    n_state = i_stat.s2_more ? ST_SRCH2 : ST_DONE;
                end
            end
            ST_SRCH2: begin
                o_cmd.s2_step = 1'b1;
                if (!i_stat.step_more) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != ST_IDLE)
        else $error("accepted beat did not start work");

    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_out_valid) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished result not handed to free output register");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("output valid raised outside result handoff");

endmodule

`default_nettype wire

### rtl/interval_window_range_finder.sv
// Top level of the interval window range finder: controller plus datapath.
// Depends on iwrf_pkg, iwrf_ctrl, iwrf_datapath.
//
//  channel | direction | handshake                  | fields
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall    | action, new_set, start_tick,
//          |           |                            | end_tick, window_low, window_high
//  out     | output    | o_out_valid / i_out_stall  | range_low, range_high,
//          |           |                            | append_rejected
//
// One beat at a time: a new beat is taken only once the result of the last one has
// moved into the output register. A query runs up to 2*ceil(log2(MAX_ENTRIES+1))
// binary search steps; each step waits on the registered table read.
// Reset empties the table through the entry count; no clearing pass.
// o_in_stall is high while a beat is in work; a finished result waits in
// the output register while the next beat is taken.
`default_nettype none

module interval_window_range_finder
    import iwrf_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int TICK_BITS   = DEF_TICK_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_action,
    input  wire logic                    i_new_set,
    input  wire logic [IN_TICK_BITS-1:0] i_start_tick,
    input  wire logic [IN_TICK_BITS-1:0] i_end_tick,
    input  wire logic [IN_TICK_BITS-1:0] i_window_low,
    input  wire logic [IN_TICK_BITS-1:0] i_window_high,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic      [RANGE_BITS-1:0]   o_range_low,
    output logic      [RANGE_BITS-1:0]   o_range_high,
    output logic                         o_append_rejected
);

    t_cmd  cmd;
    t_stat stat;

    iwrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    iwrf_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TICK_BITS   (TICK_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_new_set         (i_new_set),
        .i_start_tick      (i_start_tick),
        .i_end_tick        (i_end_tick),
        .i_window_low      (i_window_low),
        .i_window_high     (i_window_high),
        .o_range_low       (o_range_low),
        .o_range_high      (o_range_high),
        .o_append_rejected (o_append_rejected)
    );

endmodule

`default_nettype wire

### tb/interval_window_range_finder_test.sv
// Self-checking testbench for interval_window_range_finder.
// Drives append and query beats, checks results in order against an in-bench prediction or a typed expectation.
// Depends on iwrf_pkg and the interval_window_range_finder RTL.
`timescale 1ns / 1ps

module interval_window_range_finder_test;
    import iwrf_pkg::*;

    localparam int          CLK_PERIOD  = 8;
    localparam int          MAX_ENTRIES = DEF_MAX_ENTRIES;
    localparam int          RAND_ITEMS  = 1350;
    localparam int          TAIL_CYCLES = 40;
    localparam longint      RUN_LIMIT   = 64'd15_000_000;
    localparam logic [31:0] TOP         = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                    action;
        logic                    new_set;
        logic [IN_TICK_BITS-1:0] start_tick;
        logic [IN_TICK_BITS-1:0] end_tick;
        logic [IN_TICK_BITS-1:0] window_low;
        logic [IN_TICK_BITS-1:0] window_high;
    } t_beat;

    typedef struct packed {
        logic [RANGE_BITS-1:0] range_low;
        logic [RANGE_BITS-1:0] range_high;
        logic                  rejected;
    } t_range;

    typedef struct packed {
        logic                    action;
        logic                    new_set;
        logic [IN_TICK_BITS-1:0] start_tick;
        logic [IN_TICK_BITS-1:0] end_tick;
        logic [IN_TICK_BITS-1:0] window_low;
        logic [IN_TICK_BITS-1:0] window_high;
        logic                    has_exp;
        logic [RANGE_BITS-1:0]   exp_low;
        logic [RANGE_BITS-1:0]   exp_high;
        logic                    exp_rej;
    } t_dir_row;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic                    i_action      = ACT_APPEND;
    logic                    i_new_set     = 1'b0;
    logic [IN_TICK_BITS-1:0] i_start_tick  = '0;
    logic [IN_TICK_BITS-1:0] i_end_tick    = '0;
    logic [IN_TICK_BITS-1:0] i_window_low  = '0;
    logic [IN_TICK_BITS-1:0] i_window_high = '0;
    logic                    i_out_stall   = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [RANGE_BITS-1:0]   o_range_low;
    logic [RANGE_BITS-1:0]   o_range_high;
    logic                    o_append_rejected;

    interval_window_range_finder uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_new_set         (i_new_set),
        .i_start_tick      (i_start_tick),
        .i_end_tick        (i_end_tick),
        .i_window_low      (i_window_low),
        .i_window_high     (i_window_high),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_range_low       (o_range_low),
        .o_range_high      (o_range_high),
        .o_append_rejected (o_append_rejected)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor copy of the interval table
    logic [IN_TICK_BITS-1:0] start_col [MAX_ENTRIES];
    logic [IN_TICK_BITS-1:0] peak_col  [MAX_ENTRIES];
    logic [IN_TICK_BITS-1:0] end_peak  = '0;
    int                      fill_count = 0;

    t_range awaited_ranges [$];
    int     mismatch_count = 0;
    int     burst_left     = 0;

    // field order: action, new_set, start, end, win_low, win_high, typed?, low, high, rejected
    t_dir_row dir_rows [0:18] = '{
        '{ACT_QUERY,  1'b0, TOP,   TOP,   32'd0,   TOP,   1'b1, 13'd0, 13'd0, 1'b0},
        '{ACT_APPEND, 1'b0, 32'd0, 32'd0, TOP,     TOP,   1'b1, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b0, TOP,   TOP,   32'd0,   32'd0, 1'b0, 13'd0, 13'd0, 1'b0},
        '{ACT_APPEND, 1'b0, 32'd10, 32'd100, TOP,  TOP,   1'b1, 13'd0, 13'd0, 1'b0},
        '{ACT_APPEND, 1'b0, 32'd20, 32'd50,  TOP,  TOP,   1'b1, 13'd0, 13'd0, 1'b0},
        '{ACT_APPEND, 1'b0, 32'd30, TOP,     TOP,  TOP,   1'b1, 13'd0, 13'd0, 1'b0},
        // start goes backward: searches run on the unsorted column anyway
        '{ACT_APPEND, 1'b0, 32'd5,  32'd7,   TOP,  TOP,   1'b1, 13'd0, 13'd0, 1'b0},
        '{ACT_APPEND, 1'b0, TOP,    32'd0,   TOP,  TOP,   1'b1, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b1, TOP,   TOP,   32'd0,   TOP,     1'b0, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b0, TOP,   TOP,   32'd101, 32'd200, 1'b0, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b0, 32'd0, 32'd0, TOP,     TOP,     1'b0, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b0, TOP,   TOP,   32'd200, 32'd10,  1'b0, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b0, TOP,   TOP,   32'd0,   32'd0,   1'b0, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b0, TOP,   TOP,   32'd50,  32'd25,  1'b0, 13'd0, 13'd0, 1'b0},
        '{ACT_APPEND, 1'b1, TOP,   TOP,   32'd0,   32'd0,   1'b1, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b0, 32'd0, 32'd0, TOP,     TOP,     1'b0, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b0, 32'd0, 32'd0, 32'd0,   TOP - 1, 1'b0, 13'd0, 13'd0, 1'b0},
        '{ACT_APPEND, 1'b1, 32'd0, 32'd0, TOP,     TOP,     1'b1, 13'd0, 13'd0, 1'b0},
        '{ACT_QUERY,  1'b0, TOP,   TOP,   32'd1,   TOP,     1'b0, 13'd0, 13'd0, 1'b0}
    };

    function automatic t_range predict_range(input t_beat b);
        t_range r;
        int     left;
        int     right;
        int     mid;
        int     lo_idx;
        r = '0;
        if (b.action == ACT_APPEND) begin
            if (b.new_set) begin
                fill_count = 0;
                end_peak   = '0;
            end
            if (fill_count >= MAX_ENTRIES) begin
                r.rejected = 1'b1;
            end else begin
                if (b.end_tick > end_peak) end_peak = b.end_tick;
                start_col[fill_count] = b.start_tick;
                peak_col[fill_count]  = end_peak;
                fill_count++;
            end
        end else if (fill_count != 0) begin
            // first entry whose running end max reaches the window low
            left  = 0;
            right = fill_count;
            while (left < right) begin
                mid = left + (right - left) / 2;
                if (peak_col[mid] < b.window_low) left = mid + 1;
                else right = mid;
            end
            lo_idx = left;
            // from there, first entry starting past the window high
            right = fill_count;
            while (left < right) begin
                mid = left + (right - left) / 2;
                if (start_col[mid] <= b.window_high) left = mid + 1;
                else right = mid;
            end
            r.range_low  = lo_idx[RANGE_BITS-1:0];
            r.range_high = left[RANGE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        b.action      = ($urandom_range(0, 1) == 1);
        b.new_set     = ($urandom_range(0, 1) == 1);
        b.start_tick  = $urandom();
        b.end_tick    = $urandom();
        b.window_low  = $urandom();
        b.window_high = $urandom();
        return b;
    endfunction

    // sender runs in bursts; a gap of idle cycles may precede each burst
    task automatic issue_beat(input t_beat b, input bit typed, input t_range typed_res);
        t_range pred;
        int     gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_action      <= b.action;
        i_new_set     <= b.new_set;
        i_start_tick  <= b.start_tick;
        i_end_tick    <= b.end_tick;
        i_window_low  <= b.window_low;
        i_window_high <= b.window_high;
        do @(posedge i_clk); while (o_in_stall);
        pred = predict_range(b);
        awaited_ranges.push_back(typed ? typed_res : pred);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_ranges.size() != 0) @(negedge i_clk);
    endtask

    // receiver stall: modes from never to mostly stalled, switched every so often
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 1);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_range got;
        t_range want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_range_low, o_range_high, o_append_rejected};
            if (awaited_ranges.size() == 0) begin
                $display("%0t: unexpected result beat low=%0d high=%0d rej=%0b",
                         $time, got.range_low, got.range_high, got.rejected);
                mismatch_count++;
            end else begin
                want = awaited_ranges.pop_front();
                if (got.range_low !== want.range_low) begin
                    $display("%0t: range_low expected %0d actual %0d",
                             $time, want.range_low, got.range_low);
                    mismatch_count++;
                end
                if (got.range_high !== want.range_high) begin
                    $display("%0t: range_high expected %0d actual %0d",
                             $time, want.range_high, got.range_high);
                    mismatch_count++;
                end
                if (got.rejected !== want.rejected) begin
                    $display("%0t: append_rejected expected %0b actual %0b",
                             $time, want.rejected, got.rejected);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_beat              b;
        t_beat              q;
        logic [31:0]        tick;
        logic [31:0]        set_first;
        int                 k;
        int                 set_len;
        int                 rand_sent;
        bit                 sorted;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            b = '{dir_rows[i].action, dir_rows[i].new_set, dir_rows[i].start_tick,
                  dir_rows[i].end_tick, dir_rows[i].window_low, dir_rows[i].window_high};
            issue_beat(b, dir_rows[i].has_exp,
                       '{dir_rows[i].exp_low, dir_rows[i].exp_high, dir_rows[i].exp_rej});
        end
        drain_results();

        // fill the table to capacity, with queries sprinkled in
        tick = '0;
        for (k = 0; k < MAX_ENTRIES; k++) begin
            b            = random_beat();
            b.action     = ACT_APPEND;
            b.new_set    = (k == 0);
            tick         = tick + $urandom_range(0, 31);
            b.start_tick = tick;
            b.end_tick   = tick + $urandom_range(0, 2000);
            issue_beat(b, 1'b0, '0);
            if ($urandom_range(0, 15) == 0) begin
                q             = random_beat();
                q.action      = ACT_QUERY;
                q.window_low  = $urandom_range(0, tick + 2000);
                q.window_high = q.window_low + $urandom_range(0, 3000);
                issue_beat(q, 1'b0, '0);
            end
        end
        // full table: appends bounce, full-span query covers every entry
        b = '{ACT_APPEND, 1'b0, TOP, TOP, 32'd0, 32'd0};
        issue_beat(b, 1'b1, '{13'd0, 13'd0, 1'b1});
        b = '{ACT_QUERY, 1'b0, 32'd0, 32'd0, 32'd0, TOP};
        issue_beat(b, 1'b1, '{13'd0, 13'd4096, 1'b0});
        b = '{ACT_QUERY, 1'b1, 32'd0, 32'd0, TOP, TOP};
        issue_beat(b, 1'b0, '0);
        b = '{ACT_APPEND, 1'b0, 32'd0, 32'd0, TOP, TOP};
        issue_beat(b, 1'b1, '{13'd0, 13'd0, 1'b1});
        for (k = 0; k < 12; k++) begin
            q             = random_beat();
            q.action      = ACT_QUERY;
            q.window_low  = $urandom_range(0, tick + 2500);
            q.window_high = ($urandom_range(0, 3) == 0) ? q.window_low - $urandom_range(1, 500)
                                                         : q.window_low + $urandom_range(0, 4000);
            issue_beat(q, 1'b0, '0);
        end
        drain_results();

        // random sets: mostly sorted appends with queries aimed at the stored span
        rand_sent = 0;
        set_first = '0;
        tick      = '0;
        while (rand_sent < RAND_ITEMS) begin
            set_len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 200)
                                                   : $urandom_range(1, 24);
            sorted  = ($urandom_range(0, 9) != 0);
            for (k = 0; k < set_len; k++) begin
                b        = random_beat();
                b.action = ACT_APPEND;
                if (k == 0) begin
                    b.new_set = ($urandom_range(0, 7) != 0);
                    tick = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 5000);
                    set_first = tick;
                end else begin
                    b.new_set = ($urandom_range(0, 63) == 0);
                    tick = sorted ? tick + $urandom_range(0, 40) : $urandom();
                end
                b.start_tick = tick;
                b.end_tick   = ($urandom_range(0, 15) == 0) ? $urandom()
                                                            : tick + $urandom_range(0, 300);
                issue_beat(b, 1'b0, '0);
                rand_sent++;
                if ($urandom_range(0, 2) == 0) begin
                    q        = random_beat();
                    q.action = ACT_QUERY;
                    if ($urandom_range(0, 5) != 0) begin
                        q.window_low = set_first - 50
                                     + $urandom_range(0, (tick - set_first) + 400);
                        q.window_high = ($urandom_range(0, 9) == 0)
                                      ? q.window_low - $urandom_range(1, 300)
                                      : q.window_low + $urandom_range(0, 400);
                    end
                    issue_beat(q, 1'b0, '0);
                    rand_sent++;
                end
            end
        end
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && awaited_ranges.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
